// ----- sv/pbec_pkg.sv -----
`timescale 1ns / 1ps
// pbec_pkg: shared types, phase codes and constants of the pressure calibrator
// used by every module of the block and by pbec_cfg_if, no dependencies

package pbec_pkg;

  // phase codes as seen on the result channel
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BASE = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_DONE = 3'd3;
  localparam logic [2:0] PH_ERR  = 3'd4;

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATM_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_TIME   = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // timing constants in ms
  localparam logic [16:0] BASE_TICK_MS  = 17'd10;
  localparam logic [16:0] EXT_TICK_MS   = 17'd5;
  localparam logic [15:0] ATM_MIN_MS    = 16'd200;
  localparam logic [15:0] EXT_MIN_MS    = 16'd1000;
  localparam logic [15:0] ATM_RESET_MS  = 16'd600;
  localparam logic [15:0] EXT_RESET_MS  = 16'd5000;

  localparam logic signed [31:0] MIN_INIT = 32'sh7fff_ffff;
  localparam logic signed [31:0] MAX_INIT = 32'sh8000_0001;

  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned ELAPSED_W = 17;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic exec;      // apply the request to the state
    logic check;     // end of phase evaluation
    logic div_start; // launch the rounded mean division
    logic div_load;  // take the mean and enter the extremes phase
    logic out_load;  // load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } ctrl_stat_t;

endpackage

// ----- sv/pbec_in_if.sv -----
`timescale 1ns / 1ps
// pbec_in_if: request channel of the pressure calibrator
// depends on nothing but the handshake convention valid and ready

interface pbec_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               read_ok;
  logic signed [31:0] pressure_pa;

  modport source (output valid, output op, output read_ok, output pressure_pa, input ready);
  modport sink   (input valid, input op, input read_ok, input pressure_pa, output ready);
endinterface

// ----- sv/pbec_out_if.sv -----
`timescale 1ns / 1ps
// pbec_out_if: result channel of the pressure calibrator
// depends on nothing but the handshake convention valid and ready

interface pbec_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic signed [31:0] baseline_pa;
  logic signed [31:0] min_pa;
  logic signed [31:0] max_pa;

  modport source (output valid, output phase, output baseline_pa, output min_pa,
                  output max_pa, input ready);
  modport sink   (input valid, input phase, input baseline_pa, input min_pa,
                  input max_pa, output ready);
endinterface

// ----- sv/pbec_cfg_if.sv -----
`timescale 1ns / 1ps
// pbec_cfg_if: configuration write channel of the pressure calibrator
// uses pbec_pkg for the index and data widths

interface pbec_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pbec_pkg::CFG_IDX_W-1:0]     index;
  logic [pbec_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/pbec_div.sv -----
`timescale 1ns / 1ps
// pbec_div: iterative restoring divider for the rounded mean of the baseline sum
// one quotient bit per cycle; uses pbec_pkg for the sum and count widths

module pbec_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pbec_pkg::SUM_W-1:0]   sum,
  input  logic [pbec_pkg::CNT_W-1:0]          count,
  output logic                                done,
  output logic signed [31:0]                  mean
);

  localparam int unsigned NUM_W = pbec_pkg::SUM_W + 1;
  localparam int unsigned DEN_W = pbec_pkg::CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic                busy;
  logic                prep;
  logic                neg;
  logic [STEP_W-1:0]   step;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    den;
  logic [DEN_W:0]      trial;
  logic                qbit;
  logic [DEN_W:0]      diff;

  assign trial = {rem, num[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      prep <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        prep <= 1'b1;
      end else if (prep) begin
        prep <= 1'b0;
        step <= STEP_W'(NUM_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // magnitude of the sum, then 2*mag + n over 2*n
      neg <= sum[pbec_pkg::SUM_W-1];
      num <= {1'b0, (sum[pbec_pkg::SUM_W-1] ? (~sum + pbec_pkg::SUM_W'(1)) : sum)};
      den <= {count, 1'b0};
    end else if (prep) begin
      num <= {num[NUM_W-2:0], 1'b0} + NUM_W'(count);
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num <= {num[NUM_W-2:0], qbit};
    end
  end

  assign mean = neg ? (32'sd0 - $signed(num[31:0])) : $signed(num[31:0]);

endmodule

// ----- sv/pbec_datapath.sv -----
`timescale 1ns / 1ps
// pbec_datapath: configuration registers, calibration state, result register
// uses pbec_pkg, the channel interfaces and pbec_div for the baseline mean

module pbec_datapath (
  input  logic                    clk,
  input  logic                    rst,
  pbec_cfg_if.sink                cfg_ch,
  input  logic                    in_op,
  input  logic                    in_read_ok,
  input  logic signed [31:0]      in_pressure_pa,
  input  pbec_pkg::ctrl_cmd_t     cmd,
  output pbec_pkg::ctrl_stat_t    stat,
  output logic [2:0]              out_phase,
  output logic signed [31:0]      out_baseline_pa,
  output logic signed [31:0]      out_min_pa,
  output logic signed [31:0]      out_max_pa
);

  logic                                  cal_enable;
  logic [15:0]                           atm_time_ms;
  logic [15:0]                           ext_time_ms;

  logic                                  it_op;
  logic                                  it_ok;
  logic signed [31:0]                    it_p;

  logic [2:0]                            phase_reg;
  logic [pbec_pkg::ELAPSED_W-1:0]        elapsed_ms;
  logic signed [pbec_pkg::SUM_W-1:0]     sample_sum;
  logic [pbec_pkg::CNT_W-1:0]            sample_count;
  logic signed [31:0]                    baseline_reg;
  logic signed [31:0]                    min_reg;
  logic signed [31:0]                    max_reg;

  logic [15:0]                           eff_atm;
  logic [15:0]                           eff_ext;
  logic                                  base_end;
  logic                                  ext_end;
  logic                                  div_done;
  logic signed [31:0]                    mean;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_enable  <= 1'b0;
      atm_time_ms <= pbec_pkg::ATM_RESET_MS;
      ext_time_ms <= pbec_pkg::EXT_RESET_MS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pbec_pkg::CFG_CAL_ENABLE: cal_enable  <= cfg_ch.data[0];
        pbec_pkg::CFG_ATM_TIME:   atm_time_ms <= cfg_ch.data;
        pbec_pkg::CFG_EXT_TIME:   ext_time_ms <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op <= in_op;
      it_ok <= in_read_ok;
      it_p  <= in_pressure_pa;
    end
  end

  assign eff_atm = (atm_time_ms < pbec_pkg::ATM_MIN_MS) ? pbec_pkg::ATM_MIN_MS : atm_time_ms;
  assign eff_ext = (ext_time_ms < pbec_pkg::EXT_MIN_MS) ? pbec_pkg::EXT_MIN_MS : ext_time_ms;

  assign base_end = (it_op == pbec_pkg::OP_READ) && (phase_reg == pbec_pkg::PH_BASE) &&
                    (elapsed_ms >= {1'b0, eff_atm});
  assign ext_end  = (it_op == pbec_pkg::OP_READ) && (phase_reg == pbec_pkg::PH_EXT) &&
                    (elapsed_ms >= {1'b0, eff_ext});

  assign stat.need_div = base_end && (sample_count != '0);
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= pbec_pkg::PH_IDLE;
      elapsed_ms   <= '0;
      sample_sum   <= '0;
      sample_count <= '0;
      baseline_reg <= '0;
      min_reg      <= pbec_pkg::MIN_INIT;
      max_reg      <= pbec_pkg::MAX_INIT;
    end else if (cmd.exec) begin
      if (it_op == pbec_pkg::OP_START) begin
        if (!cal_enable) begin
          phase_reg <= pbec_pkg::PH_ERR;
        end else begin
          phase_reg    <= pbec_pkg::PH_BASE;
          elapsed_ms   <= '0;
          sample_sum   <= '0;
          sample_count <= '0;
          baseline_reg <= '0;
          min_reg      <= pbec_pkg::MIN_INIT;
          max_reg      <= pbec_pkg::MAX_INIT;
        end
      end else if (phase_reg == pbec_pkg::PH_BASE) begin
        if (it_ok) begin
          sample_sum   <= sample_sum + {{(pbec_pkg::SUM_W-32){it_p[31]}}, it_p};
          sample_count <= sample_count + pbec_pkg::CNT_W'(1);
        end
        elapsed_ms <= elapsed_ms + pbec_pkg::BASE_TICK_MS;
      end else if (phase_reg == pbec_pkg::PH_EXT) begin
        if (it_ok) begin
          if (it_p < min_reg) begin
            min_reg <= it_p;
          end
          if (it_p > max_reg) begin
            max_reg <= it_p;
          end
        end
        elapsed_ms <= elapsed_ms + pbec_pkg::EXT_TICK_MS;
      end
    end else if (cmd.check) begin
      if (base_end && (sample_count == '0)) begin
        phase_reg <= pbec_pkg::PH_ERR;
      end else if (ext_end) begin
        phase_reg <= (min_reg < max_reg) ? pbec_pkg::PH_DONE : pbec_pkg::PH_ERR;
      end
    end else if (cmd.div_load) begin
      baseline_reg <= mean;
      phase_reg    <= pbec_pkg::PH_EXT;
      elapsed_ms   <= '0;
      min_reg      <= pbec_pkg::MIN_INIT;
      max_reg      <= pbec_pkg::MAX_INIT;
    end
  end

  pbec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .sum   (sample_sum),
    .count (sample_count),
    .done  (div_done),
    .mean  (mean)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_phase       <= phase_reg;
      out_baseline_pa <= baseline_reg;
      out_min_pa      <= min_reg;
      out_max_pa      <= max_reg;
    end
  end

endmodule

// ----- sv/pbec_ctrl.sv -----
`timescale 1ns / 1ps
// pbec_ctrl: sequencing state machine and result valid flag of the calibrator
// uses pbec_pkg for the command and status structs

module pbec_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  pbec_pkg::ctrl_stat_t   stat,
  output pbec_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.capture   = in_valid && in_ready;
    cmd.exec      = (state == S_EXEC);
    cmd.check     = (state == S_CHECK);
    cmd.div_start = (state == S_CHECK) && stat.need_div;
    cmd.div_load  = (state == S_DIV) && stat.div_done;
    cmd.out_load  = (state == S_RESULT) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   state_next = S_CHECK;
      S_CHECK:  state_next = stat.need_div ? S_DIV : S_RESULT;
      S_DIV:    if (stat.div_done) state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/pressure_baseline_extremes_calibrator_unit.sv -----
`timescale 1ns / 1ps
// pressure_baseline_extremes_calibrator_unit: top level of the pressure calibrator
// joins pbec_ctrl and pbec_datapath; uses pbec_pkg and the three channel interfaces
//
// usage
//   in_ch carries one request: op start (0) or one read attempt (1), with read_ok
//   and pressure_pa. every request gives exactly one result on out_ch: phase,
//   baseline_pa, min_pa and max_pa as they stand after that request.
//   cfg_ch writes cal_enable (index 0), atm_time_ms (1) and ext_time_ms (2); it is
//   always ready, other indexes are dropped. write it only while the block is idle.
// sequencing
//   an accepted request passes through the exec and check states and then loads
//   the result register, which is offered on out_ch as it is loaded; the read
//   that closes the baseline phase also runs the rounded mean through the
//   one-bit-per-cycle divider (a setup step, the quotient bits, then a step to
//   take the mean) before the result. one request is in work at a time: a new
//   one is taken only once the result of the last is loaded.
// reset
//   rst is synchronous: phase idle, counters and sum cleared, config at its
//   defaults (disabled, 600 ms, 5000 ms), no result pending.
// stalls
//   the result sits in an output register; a new request is taken while it
//   waits, and the following result is held back until out_ch takes the last one.

module pressure_baseline_extremes_calibrator_unit (
  input  logic        clk,
  input  logic        rst,
  pbec_in_if.sink     in_ch,
  pbec_out_if.source  out_ch,
  pbec_cfg_if.sink    cfg_ch
);

  pbec_pkg::ctrl_cmd_t  cmd;
  pbec_pkg::ctrl_stat_t stat;

  pbec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbec_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_ch          (cfg_ch),
    .in_op           (in_ch.op),
    .in_read_ok      (in_ch.read_ok),
    .in_pressure_pa  (in_ch.pressure_pa),
    .cmd             (cmd),
    .stat            (stat),
    .out_phase       (out_ch.phase),
    .out_baseline_pa (out_ch.baseline_pa),
    .out_min_pa      (out_ch.min_pa),
    .out_max_pa      (out_ch.max_pa)
  );

endmodule

// ----- bench/pressure_baseline_extremes_calibrator_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench for pressure_baseline_extremes_calibrator_unit: directed and random calibration
// runs checked against an in-bench model of the phases; uses pbec_pkg and the channel interfaces

module pressure_baseline_extremes_calibrator_unit_tb;

  localparam logic [16:0] TICK_BASE_MS   = 17'd10;
  localparam logic [16:0] TICK_EXT_MS    = 17'd5;
  localparam logic [15:0] ATM_FLOOR_MS   = 16'd200;
  localparam logic [15:0] EXT_FLOOR_MS   = 16'd1000;
  localparam logic [15:0] ATM_DEFAULT_MS = 16'd600;
  localparam logic [15:0] EXT_DEFAULT_MS = 16'd5000;
  localparam logic [15:0] DURATION_MAX   = 16'hffff;
  localparam logic signed [31:0] MIN_START = 32'sh7fff_ffff;
  localparam logic signed [31:0] MAX_START = -32'sd2147483647;
  localparam logic signed [31:0] P_MOST    = 32'sh7fff_ffff;
  localparam logic signed [31:0] P_LEAST   = 32'sh8000_0000;
  localparam logic [pbec_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 70;
  localparam int RANDOM_ITEMS   = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int LONG_RUN_READS = 100;

  typedef struct {
    logic [2:0]         phase;
    logic signed [31:0] baseline_pa;
    logic signed [31:0] min_pa;
    logic signed [31:0] max_pa;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst;

  pbec_in_if  req_if ();
  pbec_out_if res_if ();
  pbec_cfg_if cfg_if ();

  pressure_baseline_extremes_calibrator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_if),
    .out_ch (res_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the block: settings and calibration state
  logic               en_setting  = 1'b0;
  logic [15:0]        atm_setting = ATM_DEFAULT_MS;
  logic [15:0]        ext_setting = EXT_DEFAULT_MS;
  logic [2:0]         cal_phase   = pbec_pkg::PH_IDLE;
  logic [16:0]        elapsed     = '0;
  logic signed [47:0] sample_total = '0;
  logic [12:0]        sample_count = '0;
  logic signed [31:0] baseline_mean = '0;
  logic signed [31:0] min_seen = MIN_START;
  logic signed [31:0] max_seen = MAX_START;

  cal_result_t expected_results[$];
  int          failures    = 0;
  int          busy_items  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned hold_cycles = 0;

  // mean of the baseline samples, rounded half away from zero
  function automatic logic signed [31:0] mean_half_away(input logic signed [47:0] total,
                                                        input logic [12:0] n);
    longint          t;
    longint unsigned mag;
    longint unsigned q;
    logic [31:0]     q32;
    t   = total;
    mag = (t < 0) ? -t : t;
    q   = (2 * mag + n) / (2 * longint'(n));
    q32 = q[31:0];
    return (t < 0) ? -q32 : q32;
  endfunction

  task automatic advance_calibration(input logic op, input logic ok,
                                     input logic signed [31:0] p);
    cal_result_t res;
    logic [16:0] atm_limit;
    logic [16:0] ext_limit;
    atm_limit = {1'b0, ((atm_setting < ATM_FLOOR_MS) ? ATM_FLOOR_MS : atm_setting)};
    ext_limit = {1'b0, ((ext_setting < EXT_FLOOR_MS) ? EXT_FLOOR_MS : ext_setting)};
    if (op == pbec_pkg::OP_START) begin
      if (!en_setting) begin
        cal_phase = pbec_pkg::PH_ERR;
      end else begin
        cal_phase     = pbec_pkg::PH_BASE;
        elapsed       = '0;
        sample_total  = '0;
        sample_count  = '0;
        baseline_mean = '0;
        min_seen      = MIN_START;
        max_seen      = MAX_START;
      end
    end else if (cal_phase == pbec_pkg::PH_BASE) begin
      if (ok) begin
        sample_total = sample_total + {{16{p[31]}}, p};
        sample_count = sample_count + 13'd1;
      end
      elapsed = elapsed + TICK_BASE_MS;
      if (elapsed >= atm_limit) begin
        if (sample_count == 0) begin
          cal_phase = pbec_pkg::PH_ERR;
        end else begin
          baseline_mean = mean_half_away(sample_total, sample_count);
          cal_phase     = pbec_pkg::PH_EXT;
          elapsed       = '0;
          min_seen      = MIN_START;
          max_seen      = MAX_START;
        end
      end
    end else if (cal_phase == pbec_pkg::PH_EXT) begin
      if (ok) begin
        if (p < min_seen) min_seen = p;
        if (p > max_seen) max_seen = p;
      end
      elapsed = elapsed + TICK_EXT_MS;
      if (elapsed >= ext_limit) begin
        cal_phase = (min_seen < max_seen) ? pbec_pkg::PH_DONE : pbec_pkg::PH_ERR;
      end
    end
    res.phase       = cal_phase;
    res.baseline_pa = baseline_mean;
    res.min_pa      = min_seen;
    res.max_pa      = max_seen;
    expected_results.push_back(res);
  endtask

  // one request: random gap when gaps_on, then hold valid until the block takes it
  task automatic send_request(input logic op, input logic ok, input logic signed [31:0] p);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.op          = op;
    req_if.read_ok     = ok;
    req_if.pressure_pa = p;
    do @(posedge clk); while (!req_if.ready);
    if (op == pbec_pkg::OP_START || cal_phase == pbec_pkg::PH_BASE ||
        cal_phase == pbec_pkg::PH_EXT) busy_items++;
    advance_calibration(op, ok, p);
  endtask

  task automatic write_setting(input logic [pbec_pkg::CFG_IDX_W-1:0] idx,
                               input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      pbec_pkg::CFG_CAL_ENABLE: en_setting  = value[0];
      pbec_pkg::CFG_ATM_TIME:   atm_setting = value;
      pbec_pkg::CFG_EXT_TIME:   ext_setting = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // drop valid, wait for every outstanding result, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [31:0] draw_pressure(input bit relative);
    case ($urandom_range(0, 15))
      0:       return P_MOST;
      1:       return P_LEAST;
      2:       return MAX_START;
      3:       return 32'sd0;
      4, 5:    return $urandom;
      default: return relative ? int'($urandom_range(0, 8000)) - 4000
                               : 101325 + int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  // start a run and feed read attempts, with random restarts, until it reaches done or error
  task automatic run_calibration(input int unsigned ok_base_pct, input int unsigned ok_ext_pct,
                                 input int unsigned restart_permille);
    logic ok;
    send_request(pbec_pkg::OP_START, 1'($urandom_range(0, 1)), $urandom);
    while (cal_phase == pbec_pkg::PH_BASE || cal_phase == pbec_pkg::PH_EXT) begin
      if ($urandom_range(0, 999) < restart_permille) begin
        send_request(pbec_pkg::OP_START, 1'($urandom_range(0, 1)), $urandom);
      end else if (cal_phase == pbec_pkg::PH_BASE) begin
        ok = $urandom_range(0, 99) < ok_base_pct;
        send_request(pbec_pkg::OP_READ, ok, draw_pressure(1'b0));
      end else begin
        ok = $urandom_range(0, 99) < ok_ext_pct;
        send_request(pbec_pkg::OP_READ, ok, draw_pressure(1'b1));
      end
    end
    // stray attempts after the run are ignored
    repeat ($urandom_range(0, 2)) begin
      send_request(pbec_pkg::OP_READ, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic test_idle_and_disabled();
    send_request(pbec_pkg::OP_READ, 1'b1, P_MOST);
    send_request(pbec_pkg::OP_START, 1'b1, P_LEAST);
    send_request(pbec_pkg::OP_READ, 1'b1, 32'sd101325);
    drain_results();
    write_setting(CFG_UNUSED, 16'hffff);
    write_setting(pbec_pkg::CFG_CAL_ENABLE, 16'hfffe);
    send_request(pbec_pkg::OP_START, 1'b0, 32'sd0);
    drain_results();
    // enable, with both durations below their floors
    write_setting(pbec_pkg::CFG_CAL_ENABLE, 16'h0001);
    write_setting(pbec_pkg::CFG_ATM_TIME, 16'h0000);
    write_setting(pbec_pkg::CFG_EXT_TIME, 16'h0000);
  endtask

  task automatic test_empty_baseline();
    send_request(pbec_pkg::OP_START, 1'b0, $urandom);
    while (cal_phase == pbec_pkg::PH_BASE) send_request(pbec_pkg::OP_READ, 1'b0, $urandom);
    send_request(pbec_pkg::OP_READ, 1'b1, $urandom);
    drain_results();
  endtask

  task automatic test_extreme_values();
    int i;
    send_request(pbec_pkg::OP_START, 1'b1, P_MOST);
    // two most negative samples: the mean lands exactly on a half
    for (i = 0; cal_phase == pbec_pkg::PH_BASE; i++) begin
      case (i)
        0:       send_request(pbec_pkg::OP_READ, 1'b1, P_LEAST);
        1:       send_request(pbec_pkg::OP_READ, 1'b1, MAX_START);
        default: send_request(pbec_pkg::OP_READ, 1'b0, $urandom);
      endcase
    end
    for (i = 0; cal_phase == pbec_pkg::PH_EXT; i++) begin
      case (i)
        3:       send_request(pbec_pkg::OP_READ, 1'b1, P_MOST);
        7:       send_request(pbec_pkg::OP_READ, 1'b1, P_LEAST);
        11:      send_request(pbec_pkg::OP_READ, 1'b1, 32'sd0);
        default: send_request(pbec_pkg::OP_READ, 1'b0, $urandom);
      endcase
    end
    send_request(pbec_pkg::OP_READ, 1'b1, 32'sd5);
    // restart in the middle of a run
    send_request(pbec_pkg::OP_START, 1'b0, 32'sd0);
    repeat (3) send_request(pbec_pkg::OP_READ, 1'b1, draw_pressure(1'b0));
    send_request(pbec_pkg::OP_START, 1'b1, 32'sd0);
    for (i = 0; cal_phase == pbec_pkg::PH_BASE; i++) begin
      send_request(pbec_pkg::OP_READ, i < 2, (i == 0) ? 32'sd1 : 32'sd2);
    end
    // a single extreme sample leaves min equal to max
    for (i = 0; cal_phase == pbec_pkg::PH_EXT; i++) begin
      send_request(pbec_pkg::OP_READ, i == 4, 32'sd5);
    end
    drain_results();
  endtask

  task automatic test_output_backpressure();
    write_setting(pbec_pkg::CFG_CAL_ENABLE, 16'h0001);
    write_setting(pbec_pkg::CFG_ATM_TIME, ATM_FLOOR_MS);
    write_setting(pbec_pkg::CFG_EXT_TIME, EXT_FLOOR_MS);
    gaps_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    run_calibration(100, 60, 0);
    drain_results();
    gaps_on = 1'b1;
  endtask

  // the longest windows keep the run in its baseline phase, then a restart
  task automatic test_longest_durations();
    int i;
    write_setting(pbec_pkg::CFG_CAL_ENABLE, 16'h0001);
    write_setting(pbec_pkg::CFG_ATM_TIME, DURATION_MAX);
    write_setting(pbec_pkg::CFG_EXT_TIME, DURATION_MAX);
    gaps_on = 1'b0;
    send_request(pbec_pkg::OP_START, 1'b1, 32'sd0);
    for (i = 0; i < LONG_RUN_READS; i++) begin
      send_request(pbec_pkg::OP_READ, $urandom_range(0, 19) != 0, draw_pressure(1'b0));
    end
    send_request(pbec_pkg::OP_START, 1'b0, 32'sd0);
    send_request(pbec_pkg::OP_READ, 1'b1, 32'sd101325);
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_runs();
    int          first;
    int unsigned ok_base;
    int unsigned ok_ext;
    first = busy_items;
    while (busy_items - first < RANDOM_ITEMS) begin
      drain_results();
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) != 0) begin
        write_setting(pbec_pkg::CFG_CAL_ENABLE,
                      {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 7) != 0)});
      end
      case ($urandom_range(0, 5))
        0:       write_setting(pbec_pkg::CFG_ATM_TIME, ATM_FLOOR_MS);
        1:       write_setting(pbec_pkg::CFG_ATM_TIME, 16'($urandom_range(0, 199)));
        2:       ;
        default: write_setting(pbec_pkg::CFG_ATM_TIME, 16'($urandom_range(200, 330)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_setting(pbec_pkg::CFG_EXT_TIME, EXT_FLOOR_MS);
        1:       write_setting(pbec_pkg::CFG_EXT_TIME, 16'($urandom_range(0, 999)));
        2:       ;
        default: write_setting(pbec_pkg::CFG_EXT_TIME, 16'($urandom_range(1000, 1150)));
      endcase
      if ($urandom_range(0, 3) == 0) write_setting(CFG_UNUSED, 16'($urandom));
      case ($urandom_range(0, 5))
        0:       ok_base = 0;
        1:       ok_base = 5;
        2:       ok_base = 50;
        default: ok_base = 90;
      endcase
      case ($urandom_range(0, 5))
        0:       ok_ext = 0;
        1:       ok_ext = 1;
        2:       ok_ext = 100;
        default: ok_ext = 40;
      endcase
      run_calibration(ok_base, ok_ext, ($urandom_range(0, 2) == 0) ? 4 : 0);
    end
    drain_results();
  endtask

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // result side: random stalls, one long hold when asked, checks every result
  initial begin : result_sink
    int unsigned stall;
    cal_result_t want;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 12) : 0;
      end
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, phase %0d", $time, res_if.phase);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("phase", {29'd0, want.phase}, {29'd0, res_if.phase});
        check_field("baseline_pa", want.baseline_pa, res_if.baseline_pa);
        check_field("min_pa", want.min_pa, res_if.min_pa);
        check_field("max_pa", want.max_pa, res_if.max_pa);
      end
      @(negedge clk);
    end
  end

  initial begin
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.op          = pbec_pkg::OP_START;
    req_if.read_ok     = 1'b0;
    req_if.pressure_pa = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = pbec_pkg::CFG_CAL_ENABLE;
    cfg_if.data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_and_disabled();
    test_empty_baseline();
    test_extreme_values();
    test_output_backpressure();
    test_random_runs();
    test_longest_durations();

    drain_results();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
